FILE: src/assert_macros.svh
// Assertion macros used by the phrase matching RTL (lz78_match).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LZ_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LZ_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define LZ_ASSERT(lbl, clk, rstn, prop, msg)
`define LZ_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

FILE: src/lz78_pkg.sv
// Types and constants of the LZ78 encoder.
`timescale 1ns / 1ps
package lz78_pkg;
	localparam int DICT_SIZE = 256;
	localparam int BYTE_W    = 8;
	localparam int IDX_W     = 8;
	localparam int KEY_W     = IDX_W + BYTE_W;
	localparam int EPOCH_W   = 8;

	// Highest entry index; reaching it forces a dictionary clear.
	localparam int CAP_INT = (DICT_SIZE - 1 > 255) ? 255 : DICT_SIZE - 1;
	localparam logic [IDX_W:0] CNT_CAP = 9'(CAP_INT);

	localparam logic [BYTE_W-1:0]  LIMIT_RESET = 8'd254;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'hFF;
	localparam logic [EPOCH_W-1:0] EPOCH_SWEEP = 8'd0;
	localparam logic [KEY_W-1:0]   KEY_LAST    = 16'hFFFF;

	typedef logic [KEY_W-1:0] key_t;

	// One child map entry, tagged with the dictionary generation that wrote it.
	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [IDX_W-1:0]   child;
	} dict_word_t;

	typedef struct packed {
		logic       re;
		key_t       raddr;
		logic       we;
		key_t       waddr;
		dict_word_t wdata;
	} mem_req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  phrase_index;
		logic [BYTE_W-1:0] next_byte;
		logic              end_of_stream;
	} result_t;
endpackage

FILE: src/lz78_dict_mem.sv
// Child map memory: one write port, one registered read port, write-through on collision.
`timescale 1ns / 1ps
module lz78_dict_mem
	import lz78_pkg::*;
(
	input  logic       clk,
	input  mem_req_t   req,
	output dict_word_t rdata
);
	dict_word_t mem [1 << KEY_W];
	dict_word_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// a read of the entry written in the same cycle returns the new word
	always_ff @(posedge clk) begin
		if (req.re) begin
			if (req.we && (req.waddr == req.raddr)) begin
				rdata_q <= req.wdata;
			end else begin
				rdata_q <= mem[req.raddr];
			end
		end
	end

	assign rdata = rdata_q;
endmodule

FILE: src/lz78_match.sv
// Phrase matching: lookup stage, phrase state, entry count, generation tags and sweep.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lz78_match
	import lz78_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last,
	input  logic [BYTE_W-1:0] limit,
	output logic              res_valid,
	input  logic              res_ready,
	output result_t           res,
	output mem_req_t          mem_req,
	input  dict_word_t        mem_rdata
);
	logic              valid_s2;
	logic [IDX_W-1:0]  prefix_s2;
	logic [BYTE_W-1:0] byte_s2;
	logic              last_s2;

	logic [IDX_W-1:0]   prefix_q;
	logic [IDX_W-1:0]   count_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic               sweep_q;
	key_t               sweep_addr_q;

	logic              hit;
	logic              emit;
	logic              adv_s2;
	logic              accept;
	logic              do_clear;
	logic [IDX_W-1:0]  next_prefix;
	logic [IDX_W-1:0]  prefix_now;
	logic [IDX_W:0]    count_sum;
	logic [IDX_W-1:0]  count_new;

	// entry is live only if written in the current generation
	assign hit         = !last_s2 && (mem_rdata.epoch == epoch_q);
	assign emit        = valid_s2 && !hit;
	assign adv_s2      = valid_s2 && (hit || res_ready);
	assign next_prefix = hit ? mem_rdata.child : '0;
	assign prefix_now  = valid_s2 ? next_prefix : prefix_q;

	// hold new items while the last generation tag is in use so a wrap sweep finds no item
	assign in_stall = sweep_q || (valid_s2 && (!adv_s2 || (epoch_q == EPOCH_LAST)));
	assign accept   = in_valid && !in_stall;

	assign count_sum = {1'b0, count_q} + 9'd1;
	assign count_new = count_sum[IDX_W] ? '1 : count_sum[IDX_W-1:0];
	assign do_clear  = ({1'b0, count_new} > {1'b0, limit}) || ({1'b0, count_new} >= CNT_CAP);

	assign res_valid         = emit;
	assign res.phrase_index  = prefix_s2;
	assign res.next_byte     = byte_s2;
	assign res.end_of_stream = last_s2;

	always_comb begin
		mem_req.re    = accept;
		mem_req.raddr = {prefix_now, data_byte};
		if (sweep_q) begin
			mem_req.we          = 1'b1;
			mem_req.waddr       = sweep_addr_q;
			mem_req.wdata.epoch = EPOCH_SWEEP;
			mem_req.wdata.child = '0;
		end else begin
			mem_req.we          = emit && adv_s2;
			mem_req.waddr       = {prefix_s2, byte_s2};
			mem_req.wdata.epoch = epoch_q;
			mem_req.wdata.child = count_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (accept) begin
			valid_s2 <= 1'b1;
		end else if (adv_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prefix_s2 <= prefix_now;
			byte_s2   <= data_byte;
			last_s2   <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q     <= '0;
			count_q      <= '0;
			epoch_q      <= EPOCH_FIRST;
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
		end else if (sweep_q) begin
			sweep_addr_q <= sweep_addr_q + 16'd1;
			if (sweep_addr_q == KEY_LAST) begin
				sweep_q <= 1'b0;
				epoch_q <= EPOCH_FIRST;
			end
		end else if (adv_s2) begin
			prefix_q <= next_prefix;
			if (emit) begin
				if (do_clear) begin
					count_q <= '0;
					if (epoch_q == EPOCH_LAST) begin
						sweep_q      <= 1'b1;
						sweep_addr_q <= '0;
					end else begin
						epoch_q <= epoch_q + 8'd1;
					end
				end else begin
					count_q <= count_new;
				end
			end
		end
	end

	`LZ_ASSERT(a_count_cap, clk, arst_n, ({1'b0, count_q} < CNT_CAP), "entry count past cap")
	`LZ_ASSERT(a_prefix_known, clk, arst_n, (prefix_q <= count_q), "prefix beyond entry count")
	`LZ_ASSERT_NEVER(a_sweep_idle, clk, arst_n, (sweep_q && valid_s2), "item in flight during sweep")
	`LZ_ASSERT(a_epoch_live, clk, arst_n, (!sweep_q |-> (epoch_q != EPOCH_SWEEP)), "live epoch zero")
endmodule

FILE: src/lz78_encoder_core.sv
// LZ78 encoder top level: configuration register, output register and dictionary.
//
// Input channel: data_byte/last with in_valid/in_stall; an item is taken when in_valid
// is high and in_stall low. Output channel: phrase_index/next_byte/end_of_stream with
// out_valid/out_stall; at most one pair leaves per input byte, none while a phrase grows.
// Config: dict_limit written by cfg_valid & cfg_ready (always ready); write only when idle.
// Path: a taken byte and its dictionary read are registered in the lookup stage, then its pair
// in the output register. Throughput: one byte per cycle while in_stall is low; the next byte's
// lookup address is formed from the current lookup result, and the dictionary write of a
// finished phrase shares that cycle. In the last of the 255 generations a new byte waits
// until the lookup stage is empty. Dictionary clears bump a generation tag kept in each entry;
// after reset and on tag wrap, a sweep rewrites all 65536 child map entries with in_stall high.
// A stalled receiver holds the output register; bytes that extend the phrase are still
// looked up, and the first byte that ends a phrase holds in_stall high until the pair is taken.
`timescale 1ns / 1ps
module lz78_encoder_core
	import lz78_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [IDX_W-1:0]  phrase_index,
	output logic [BYTE_W-1:0] next_byte,
	output logic              end_of_stream,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [BYTE_W-1:0] dict_limit
);
	logic [BYTE_W-1:0] limit_q;
	logic              out_valid_q;
	result_t           out_q;
	logic              res_valid;
	logic              res_ready;
	result_t           res;
	mem_req_t          mem_req;
	dict_word_t        mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= dict_limit;
		end
	end

	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign phrase_index  = out_q.phrase_index;
	assign next_byte     = out_q.next_byte;
	assign end_of_stream = out_q.end_of_stream;

	lz78_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last      (last),
		.limit     (limit_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	lz78_dict_mem u_dict (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);
endmodule
